@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the block allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge out of reset.
`define BBA_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define BBA_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BBA_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define BBA_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif

`endif

@@ rtl/bba_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
package bba_pkg;

  localparam int MAP_BYTES = 256;
  localparam int MAP_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int IDX_W     = 9;

  typedef enum logic [2:0] {
    RES_OK    = 3'd0,
    RES_START = 3'd1,
    RES_MID   = 3'd2,
    RES_END   = 3'd3,
    RES_FULL  = 3'd4
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_SCAN,
    S_R_RD0,
    S_R_CHK0,
    S_R_SCAN,
    S_R_WS,
    S_R_WM,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_DEC,
    IDX_INC,
    IDX_MID
  } idx_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ALLOC,
    WR_START,
    WR_ZERO,
    WR_END
  } wr_op_t;

  typedef struct packed {
    logic    load;
    logic    kind;
    logic    rd;
    idx_op_t idx_op;
    logic    cap_start;
    logic    cap_end;
    wr_op_t  wr_op;
    logic    res_set;
    res_t    res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic rd_vld;
    logic byte_nz;
    logic byte_full;
    logic start_ok;
    logic end_ok;
    logic same_byte;
    logic rd_at_end;
    logic rd_at_zero;
    logic rd_more;
    logic wm_at_end;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/bba_ctrl.sv @@
// Controller state machine that sequences allocate and reserve requests.
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  bba_pkg::state_t state_r;
  bba_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.kind  = in_kind;
          state_nxt = in_kind ? bba_pkg::S_R_RD0 : bba_pkg::S_A_SCAN;
        end
      end
      bba_pkg::S_A_SCAN: begin
        if (sts.rd_vld && sts.byte_nz) begin
          cmd.wr_op    = bba_pkg::WR_ALLOC;
          cmd.res_set  = 1'b1;
          cmd.res_code = bba_pkg::RES_OK;
          state_nxt    = bba_pkg::S_DONE;
        end else if (sts.rd_vld && sts.rd_at_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = bba_pkg::RES_FULL;
          state_nxt    = bba_pkg::S_DONE;
        end else begin
          cmd.rd     = 1'b1;
          cmd.idx_op = bba_pkg::IDX_DEC;
        end
      end
      bba_pkg::S_R_RD0: begin
        cmd.rd     = 1'b1;
        cmd.idx_op = bba_pkg::IDX_INC;
        state_nxt  = bba_pkg::S_R_CHK0;
      end
      bba_pkg::S_R_CHK0: begin
        if (sts.rd_vld) begin
          if (!sts.start_ok) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = bba_pkg::RES_START;
            state_nxt    = bba_pkg::S_DONE;
          end else begin
            cmd.cap_start = 1'b1;
            state_nxt     = sts.same_byte ? bba_pkg::S_R_WS : bba_pkg::S_R_SCAN;
          end
        end
      end
      bba_pkg::S_R_SCAN: begin
        if (sts.rd_vld && sts.rd_at_end) begin
          if (!sts.end_ok) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = bba_pkg::RES_END;
          end else begin
            cmd.cap_end = 1'b1;
          end
          state_nxt = sts.end_ok ? bba_pkg::S_R_WS : bba_pkg::S_DONE;
        end else if (sts.rd_vld && !sts.byte_full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = bba_pkg::RES_MID;
          state_nxt    = bba_pkg::S_DONE;
        end else if (sts.rd_more) begin
          cmd.rd     = 1'b1;
          cmd.idx_op = bba_pkg::IDX_INC;
        end
      end
      bba_pkg::S_R_WS: begin
        cmd.wr_op  = bba_pkg::WR_START;
        cmd.idx_op = bba_pkg::IDX_MID;
        if (sts.same_byte) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = bba_pkg::RES_OK;
          state_nxt    = bba_pkg::S_DONE;
        end else begin
          state_nxt = bba_pkg::S_R_WM;
        end
      end
      bba_pkg::S_R_WM: begin
        if (sts.wm_at_end) begin
          cmd.wr_op    = bba_pkg::WR_END;
          cmd.res_set  = 1'b1;
          cmd.res_code = bba_pkg::RES_OK;
          state_nxt    = bba_pkg::S_DONE;
        end else begin
          cmd.wr_op  = bba_pkg::WR_ZERO;
          cmd.idx_op = bba_pkg::IDX_INC;
        end
      end
      bba_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bba_dp.sv @@
// Datapath: free map memory with valid bits, range decode, checks and result register.
module bba_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  bba_pkg::cmd_t cmd,
  output bba_pkg::sts_t sts,
  input  logic [23:0]   start_addr,
  input  logic [24:0]   length,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [23:0]   out_addr
);

  logic [7:0] mem [bba_pkg::MAP_BYTES];
  logic [bba_pkg::MAP_BYTES-1:0] valid_r;

  logic [7:0]              i0_r;
  logic [7:0]              i1_r;
  logic [2:0]              j0_r;
  logic [2:0]              j1_r;
  logic [bba_pkg::IDX_W-1:0] idx_r;
  logic [bba_pkg::IDX_W-1:0] idx_nxt;
  logic [7:0]              rd_data_r;
  logic                    rd_vbit_r;
  logic                    rd_inr_r;
  logic [7:0]              rd_idx_r;
  logic                    rd_vld_r;
  logic [7:0]              sb_r;
  logic [7:0]              eb_r;
  bba_pkg::res_t           res_status_r;
  logic [23:0]             res_addr_r;
  logic                    out_valid_r;
  bba_pkg::res_t           out_status_r;
  logic [23:0]             out_addr_r;

  logic [24:0] len_adj;
  logic [25:0] end_sum;
  logic [23:0] end_addr;
  logic [2:0]  j2;
  logic [7:0]  mask0;
  logic [7:0]  m0x;
  logic [7:0]  mask1;
  logic [7:0]  rd_byte;
  logic [2:0]  low_pos;
  logic [2:0]  alloc_p;
  logic [23:0] alloc_addr;
  logic                      wr_en;
  logic [bba_pkg::IDX_W-1:0] wr_idx;
  logic [7:0]                wr_data;
  logic                      rd_inr;

  // A zero length counts as one byte; a range past the top ends at the last byte.
  assign len_adj  = (length == '0) ? 25'd1 : length;
  assign end_sum  = {2'b00, start_addr} + {1'b0, len_adj} - 26'd1;
  assign end_addr = (end_sum[25:24] != 2'b00) ? 24'hffffff : end_sum[23:0];

  assign j2    = (i0_r == i1_r) ? j1_r : 3'd7;
  assign mask0 = (8'hff >> j0_r) & (8'hff << (3'd7 - j2));
  assign m0x   = mask0 & ~(8'h80 >> j0_r);
  assign mask1 = 8'hff << (3'd7 - j1_r);

  // Bytes beyond the map read as fully taken; never-written bytes read as free.
  assign rd_byte = rd_inr_r ? (rd_vbit_r ? rd_data_r : 8'hff) : 8'h00;

  always_comb begin
    low_pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (rd_byte[k]) begin
        low_pos = 3'(k);
      end
    end
  end

  assign alloc_p    = 3'd7 - low_pos;
  assign alloc_addr = {rd_idx_r, alloc_p, 13'd0};

  always_comb begin
    wr_idx  = idx_r;
    wr_data = 8'h00;
    case (cmd.wr_op)
      bba_pkg::WR_ALLOC: begin
        wr_idx  = {1'b0, rd_idx_r};
        wr_data = rd_byte & (rd_byte - 8'd1);
      end
      bba_pkg::WR_START: begin
        wr_idx  = {1'b0, i0_r};
        wr_data = sb_r;
      end
      bba_pkg::WR_ZERO: begin
        wr_idx  = idx_r;
        wr_data = 8'h00;
      end
      bba_pkg::WR_END: begin
        wr_idx  = {1'b0, i1_r};
        wr_data = eb_r;
      end
      default: begin
        wr_idx  = idx_r;
        wr_data = 8'h00;
      end
    endcase
  end

  assign wr_en  = (cmd.wr_op != bba_pkg::WR_NONE) &&
                  (wr_idx < bba_pkg::IDX_W'(bba_pkg::MAP_BYTES));
  assign rd_inr = idx_r < bba_pkg::IDX_W'(bba_pkg::MAP_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx[bba_pkg::MAP_AW-1:0]] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[idx_r[bba_pkg::MAP_AW-1:0]];
      rd_vbit_r <= valid_r[idx_r[bba_pkg::MAP_AW-1:0]];
      rd_inr_r  <= rd_inr;
      rd_idx_r  <= idx_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx[bba_pkg::MAP_AW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    case (cmd.idx_op)
      bba_pkg::IDX_DEC: idx_nxt = idx_r - 1'b1;
      bba_pkg::IDX_INC: idx_nxt = idx_r + 1'b1;
      bba_pkg::IDX_MID: idx_nxt = {1'b0, i0_r} + 1'b1;
      default:          idx_nxt = idx_r;
    endcase
    if (cmd.load) begin
      idx_nxt = cmd.kind ? {1'b0, start_addr[23:16]}
                         : bba_pkg::IDX_W'(bba_pkg::MAP_BYTES - 1);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      i0_r       <= start_addr[23:16];
      j0_r       <= start_addr[15:13];
      i1_r       <= end_addr[23:16];
      j1_r       <= end_addr[15:13];
      res_addr_r <= 24'd0;
    end else if (cmd.wr_op == bba_pkg::WR_ALLOC) begin
      res_addr_r <= alloc_addr;
    end
    if (cmd.cap_start) begin
      sb_r <= rd_byte & ~mask0;
    end
    if (cmd.cap_end) begin
      eb_r <= rd_byte & ~mask1;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.rd_vld     = rd_vld_r;
  assign sts.byte_nz    = rd_byte != 8'h00;
  assign sts.byte_full  = rd_byte == 8'hff;
  assign sts.start_ok   = (rd_byte & m0x) == m0x;
  assign sts.end_ok     = (rd_byte & mask1) == mask1;
  assign sts.same_byte  = i0_r == i1_r;
  assign sts.rd_at_end  = rd_idx_r == i1_r;
  assign sts.rd_at_zero = rd_idx_r == 8'd0;
  assign sts.rd_more    = idx_r <= {1'b0, i1_r};
  assign sts.wm_at_end  = idx_r == {1'b0, i1_r};
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_addr   = out_addr_r;

endmodule

@@ rtl/flash_block_bitmap_allocator_core.sv @@
// Top level of the flash block bitmap allocator: ports, controller, datapath, checks.
//
// Each input request either allocates the highest free 8 KiB block of a 16 MiB
// flash (in_tuser 0) or reserves a byte range (in_tuser 1). Every request gives
// exactly one result on the out_ channel: a status code and a block address.
// A reservation is all or nothing; a failed one leaves the map unchanged.
// The block serves one request at a time; in_tready is high only while idle.
// Allocation reads one map byte per cycle from the top of the map through a
// single-port memory. A reservation inside one map byte reads it and writes
// it back; one that spans more than one map byte reads each of them, then
// writes each back. A failed reservation stops at the first conflicting byte
// and ends sooner. The next request is taken in the cycle after the result
// is loaded. The result waits in an output register; a stalled receiver
// holds the block in its final state, but a new request is taken once that
// result is loaded. Synchronous reset marks every block free at once through
// per-byte valid bits, so no clearing pass is needed and a request can follow
// reset directly.
`include "assert_macros.svh"

module flash_block_bitmap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // start_addr[23:0], length[48:24], zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[2:0], block_addr[26:3], zero pad
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;
  logic [2:0]    res_status;
  logic [23:0]   res_addr;
  logic          res_err;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .start_addr (in_tdata[23:0]),
    .length     (in_tdata[48:24]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_addr   (res_addr)
  );

  assign out_tdata = {5'd0, res_addr, res_status};
  assign res_err   = res_status != bba_pkg::RES_OK;

  `BBA_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BBA_ASSERT_IMP(a_port_excl, clk, rst_n, cmd.wr_op != bba_pkg::WR_NONE, !cmd.rd)
  `BBA_ASSERT_IMP(a_fail_addr_zero, clk, rst_n, out_tvalid && res_err, res_addr == 24'd0)
  `BBA_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, res_status <= bba_pkg::RES_FULL)

endmodule
